>>> rtl/rms_pkg.sv
package rms_pkg;

    localparam int unsigned REG_COUNT_DEF   = 32;
    localparam int unsigned MEM_WORDS_DEF   = 65536;
    localparam int unsigned MAX_PROGRAM_DEF = 65536;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PC_W   = 18;
    localparam int unsigned IMM_W  = 17;
    localparam int unsigned LEN_W  = 17;
    localparam int unsigned BUD_W  = 31;
    localparam int unsigned ST_W   = 3;
    localparam int unsigned CFG_W  = 31;

    typedef enum logic [3:0] {
        OP_BLANK = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_RET   = 4'd5,
        OP_LDR   = 4'd6,
        OP_STR   = 4'd7,
        OP_MOV   = 4'd8,
        OP_JMP   = 4'd9,
        OP_JZ    = 4'd10
    } t_op;

    localparam logic [ST_W-1:0] ST_RUN    = 3'd0;
    localparam logic [ST_W-1:0] ST_RET    = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD    = 3'd2;
    localparam logic [ST_W-1:0] ST_OUT    = 3'd3;
    localparam logic [ST_W-1:0] ST_BUDGET = 3'd4;

    localparam logic CFG_LEN = 1'b0;
    localparam logic CFG_BUD = 1'b1;

    typedef struct packed {
        logic                start;
        logic                is_div;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
    } t_alu_req;

endpackage

>>> rtl/rms_alu.sv
// shared iterative unit: radix-2 signed divide or shift-add multiply
module rms_alu
    import rms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);
    localparam int unsigned CNT_W = $clog2(DATA_W + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_div, n_div;
    logic                r_neg, n_neg;
    logic [DATA_W-1:0]   r_acc, n_acc;   // remainder or product
    logic [DATA_W-1:0]   r_q, n_q;       // dividend/quotient or multiplier
    logic [DATA_W-1:0]   r_d, n_d;       // divisor magnitude or multiplicand
    logic [DATA_W:0]     w_trial;
    logic [DATA_W-1:0]   w_rem;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_neg  = r_neg;
        n_acc  = r_acc;
        n_q    = r_q;
        n_d    = r_d;
        w_rem  = {r_acc[DATA_W-2:0], r_q[DATA_W-1]};
        w_trial = {1'b0, w_rem} - {1'b0, r_d};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DATA_W);
            n_div  = i_req.is_div;
            n_acc  = '0;
            if (i_req.is_div) begin
                n_neg = i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
                n_q   = i_req.a[DATA_W-1] ? (DATA_W'(0) - i_req.a) : i_req.a;
                n_d   = i_req.b[DATA_W-1] ? (DATA_W'(0) - i_req.b) : i_req.b;
            end else begin
                n_neg = 1'b0;
                n_q   = i_req.b;
                n_d   = i_req.a;
            end
        end else if (r_busy) begin
            if (r_div) begin
                if (!w_trial[DATA_W]) begin
                    n_acc = w_trial[DATA_W-1:0];
                    n_q   = {r_q[DATA_W-2:0], 1'b1};
                end else begin
                    n_acc = w_rem;
                    n_q   = {r_q[DATA_W-2:0], 1'b0};
                end
            end else begin
                n_acc = r_acc + (r_q[0] ? r_d : '0);
                n_q   = r_q >> 1;
                n_d   = r_d << 1;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_div <= n_div;
        r_neg <= n_neg;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_done   = r_done;
    assign o_result = r_div ? (r_neg ? (DATA_W'(0) - r_q) : r_q) : r_acc;
endmodule

>>> rtl/register_machine_step.sv
// an instruction passes S_READ, S_EXEC and S_OUT before its result is registered;
// mul and div also wait in S_ALU (one bit per cycle in the shared alu);
// ldr adds S_LOAD for the registered data memory read
// one instruction in flight at a time; ready again once its result is in the output register
// after reset the data memory is swept to zero, one word at a time, with no
// input beat accepted; the register file is cleared at once by valid bits
module register_machine_step
    import rms_pkg::*;
#(
    parameter int unsigned REG_COUNT   = REG_COUNT_DEF,
    parameter int unsigned MEM_WORDS   = MEM_WORDS_DEF,
    parameter int unsigned MAX_PROGRAM = MAX_PROGRAM_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [3:0]               i_req_type,
    input  logic [4:0]               i_dest_reg,
    input  logic [4:0]               i_src_a_reg,
    input  logic [4:0]               i_src_b_reg,
    input  logic signed [IMM_W-1:0]  i_immediate,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [ST_W-1:0]          o_status,
    output logic signed [PC_W-1:0]   o_next_pc,
    output logic signed [DATA_W-1:0] o_return_value
);
    localparam int unsigned RA_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int unsigned MA_W = $clog2(MEM_WORDS);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,   // register file operands registered
        S_EXEC  = 7'b0001000,
        S_ALU   = 7'b0010000,   // waiting on the shared alu
        S_LOAD  = 7'b0100000,   // memory read data arrives
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [LEN_W-1:0] r_len;
    logic [BUD_W-1:0] r_bud;

    // architectural state
    logic [DATA_W-1:0] r_rf [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [DATA_W-1:0] r_mem [MEM_WORDS];
    logic signed [PC_W-1:0] r_pc;
    logic [DATA_W-1:0] r_cnt;
    logic r_stop;
    logic [ST_W-1:0] r_stop_st;
    logic [DATA_W-1:0] r_stop_val;
    logic [MA_W:0] r_clr;

    // captured instruction
    t_op r_op;
    logic [4:0] r_rd, r_ra, r_rb;
    logic signed [IMM_W-1:0] r_imm;
    logic [DATA_W-1:0] r_a, r_b, r_mem_q;

    // output beat
    logic r_ovld;
    logic [ST_W-1:0] r_ost;
    logic signed [PC_W-1:0] r_opc;
    logic [DATA_W-1:0] r_oval;

    t_alu_req w_alu_req;
    logic w_alu_done;
    logic [DATA_W-1:0] w_alu_res;

    rms_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    // effective program length clamps to MAX_PROGRAM
    logic [LEN_W:0] w_len;
    assign w_len = (32'(r_len) > MAX_PROGRAM) ? (LEN_W+1)'(MAX_PROGRAM) : {1'b0, r_len};

    function automatic logic [ST_W-1:0] f_check(
        input logic signed [PC_W-1:0] pc, input logic [DATA_W-1:0] cnt,
        input logic [BUD_W-1:0] bud, input logic [LEN_W:0] len);
        logic [ST_W-1:0] st;
        st = ST_RUN;
        if (bud != '0 && cnt >= {1'b0, bud})
            st = ST_BUDGET;
        else if (pc < 0 || {1'b0, pc[PC_W-2:0]} >= PC_W'(len))
            st = ST_OUT;
        return st;
    endfunction

    // register read with valid bits standing in for reset
    logic [DATA_W-1:0] w_rd_a, w_rd_b;
    logic w_ra_ok, w_rb_ok, w_rd_ok;
    assign w_ra_ok = 32'(r_ra) < REG_COUNT;
    assign w_rb_ok = 32'(r_rb) < REG_COUNT;
    assign w_rd_ok = 32'(r_rd) < REG_COUNT;
    assign w_rd_a = (w_ra_ok && r_rf_vld[RA_W'(r_ra)]) ? r_rf[RA_W'(r_ra)] : '0;
    assign w_rd_b = (w_rb_ok && r_rf_vld[RA_W'(r_rb)]) ? r_rf[RA_W'(r_rb)] : '0;

    // exec-stage decisions
    logic w_bad;
    logic [DATA_W-1:0] w_addr;
    logic w_addr_ok;
    logic signed [PC_W-1:0] w_npc;
    logic [ST_W-1:0] w_pre;
    assign w_pre  = f_check(r_pc, r_cnt, r_bud, w_len);
    assign w_addr = r_a + DATA_W'(r_imm);
    assign w_addr_ok = !w_addr[DATA_W-1] && (w_addr < DATA_W'(MEM_WORDS));

    always_comb begin
        w_bad = 1'b0;
        w_npc = r_pc + PC_W'(1);
        case (r_op)
            OP_BLANK: w_bad = 1'b0;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: w_bad = !w_rd_ok || !w_ra_ok || !w_rb_ok;
            OP_RET:   w_bad = !w_ra_ok;
            OP_LDR:   w_bad = !w_rd_ok || !w_ra_ok;
            OP_STR:   w_bad = !w_ra_ok || !w_rb_ok;
            OP_MOV:   w_bad = !w_rd_ok;
            OP_JMP:   w_npc = r_pc + PC_W'(r_imm);
            OP_JZ: begin
                w_bad = !w_ra_ok;
                if (r_a == '0) w_npc = r_pc + PC_W'(r_imm);
            end
            default:  w_bad = 1'b1;
        endcase
    end

    // shared register file write port
    logic w_rf_we;
    logic [4:0] w_rf_wa;
    logic [DATA_W-1:0] w_rf_wd;
    // finish of a non-stopping instruction
    logic w_fin;
    logic signed [PC_W-1:0] w_fin_pc;

    always_comb begin
        n_state   = r_state;
        w_rf_we   = 1'b0;
        w_rf_wa   = r_rd;
        w_rf_wd   = '0;
        w_fin     = 1'b0;
        w_fin_pc  = w_npc;
        w_alu_req = '{start: 1'b0, is_div: (r_op == OP_DIV), a: r_a, b: r_b};
        case (r_state)
            S_CLEAR: if (r_clr == (MA_W+1)'(MEM_WORDS)) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC: begin
                if (r_stop || w_pre != ST_RUN || w_bad || r_op == OP_RET) begin
                    n_state = S_OUT;
                end else begin
                    case (r_op)
                        OP_ADD: begin
                            w_rf_we = 1'b1; w_rf_wd = r_a + r_b; w_fin = 1'b1;
                            n_state = S_OUT;
                        end
                        OP_SUB: begin
                            w_rf_we = 1'b1; w_rf_wd = r_a - r_b; w_fin = 1'b1;
                            n_state = S_OUT;
                        end
                        OP_MUL, OP_DIV: begin
                            w_alu_req.start = 1'b1;
                            n_state = S_ALU;
                        end
                        OP_LDR: begin
                            if (w_addr_ok) n_state = S_LOAD;
                            else begin w_fin = 1'b1; n_state = S_OUT; end
                        end
                        OP_MOV: begin
                            w_rf_we = 1'b1; w_rf_wd = DATA_W'(r_imm); w_fin = 1'b1;
                            n_state = S_OUT;
                        end
                        default: begin
                            w_fin = 1'b1; n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_ALU: if (w_alu_done) begin
                w_rf_we = !(r_op == OP_DIV && r_b == '0);
                w_rf_wd = w_alu_res;
                w_fin   = 1'b1;
                w_fin_pc = r_pc + PC_W'(1);
                n_state = S_OUT;
            end
            S_LOAD: begin
                w_rf_we = 1'b1; w_rf_wd = r_mem_q; w_fin = 1'b1;
                w_fin_pc = r_pc + PC_W'(1);
                n_state = S_OUT;
            end
            S_OUT: if (!r_ovld || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // look-ahead check sees the count including the current instruction
    logic [DATA_W-1:0] w_cnt_now;
    assign w_cnt_now = (r_state == S_EXEC && r_cnt != '1) ? r_cnt + 1'b1 : r_cnt;

    logic [ST_W-1:0] w_post;
    assign w_post = f_check(w_fin_pc, w_cnt_now, r_bud, w_len);

    // next output beat and stop bookkeeping
    logic n_stop;
    logic [ST_W-1:0] n_stop_st;
    logic [DATA_W-1:0] n_stop_val;
    logic signed [PC_W-1:0] n_pc;
    logic w_emit;
    always_comb begin
        n_stop = r_stop; n_stop_st = r_stop_st; n_stop_val = r_stop_val; n_pc = r_pc;
        w_emit = 1'b0;
        if (r_state == S_EXEC && !r_stop) begin
            if (w_pre != ST_RUN) begin
                n_stop = 1'b1; n_stop_st = w_pre; n_stop_val = '0;
            end else if (w_bad) begin
                n_stop = 1'b1; n_stop_st = ST_BAD; n_stop_val = '0;
            end else if (r_op == OP_RET) begin
                n_stop = 1'b1; n_stop_st = ST_RET; n_stop_val = r_a;
            end
        end
        if (w_fin) begin
            n_pc = w_fin_pc;
            if (w_post != ST_RUN) begin
                n_stop = 1'b1; n_stop_st = w_post; n_stop_val = '0;
            end
        end
        // load the output register once the previous beat is gone or leaving
        if (r_state == S_OUT && (!r_ovld || i_ready)) w_emit = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_len      <= '0;
            r_bud      <= '0;
            r_rf_vld   <= '0;
            r_pc       <= '0;
            r_cnt      <= '0;
            r_stop     <= 1'b0;
            r_stop_st  <= ST_RUN;
            r_stop_val <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LEN) r_len <= i_cfg_data[LEN_W-1:0];
                else r_bud <= i_cfg_data[BUD_W-1:0];
            end
            if (w_rf_we) r_rf_vld[RA_W'(w_rf_wa)] <= 1'b1;
            // count every executed instruction, saturating
            if (r_state == S_EXEC && !r_stop && w_pre == ST_RUN && r_cnt != '1)
                r_cnt <= r_cnt + 1'b1;
            r_pc       <= n_pc;
            r_stop     <= n_stop;
            r_stop_st  <= n_stop_st;
            r_stop_val <= n_stop_val;
            if (w_emit) r_ovld <= 1'b1;
            else if (i_ready) r_ovld <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op  <= t_op'(i_req_type);
            r_rd  <= i_dest_reg;
            r_ra  <= i_src_a_reg;
            r_rb  <= i_src_b_reg;
            r_imm <= i_immediate;
        end
        if (r_state == S_READ) begin
            r_a <= w_rd_a;
            r_b <= w_rd_b;
        end
        if (w_rf_we) r_rf[RA_W'(w_rf_wa)] <= w_rf_wd;
        if (w_emit) begin
            r_ost  <= r_stop ? r_stop_st : ST_RUN;
            r_opc  <= r_pc;
            r_oval <= r_stop ? r_stop_val : '0;
        end
    end

    // data memory: one write port and one registered read port, swept to zero after reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            if (r_clr != (MA_W+1)'(MEM_WORDS)) r_mem[r_clr[MA_W-1:0]] <= '0;
        end else if (r_state == S_EXEC && !r_stop && w_pre == ST_RUN && !w_bad
                     && r_op == OP_STR && w_addr_ok) begin
            r_mem[w_addr[MA_W-1:0]] <= r_b;
        end
        r_mem_q <= r_mem[w_addr[MA_W-1:0]];
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovld;
    assign o_status       = r_ost;
    assign o_next_pc      = r_opc;
    assign o_return_value = r_oval;
endmodule
